// File: src/mst_pkg.sv
// Shared types and constants for the bottom-up merge sorter.
package mst_pkg;

	localparam int unsigned DATA_W = 32;

	typedef logic [DATA_W-1:0] word_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] element_value;
		logic                     set_last;
	} load_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] sorted_value;
		logic                     result_last;
		logic                     overflow_seen;
	} result_item_t;

endpackage

// File: src/mst_ram.sv
// Synchronous buffer memory: one write port, two read ports with registered read data.
module mst_ram import mst_pkg::*; #(
	parameter int unsigned AW = 6
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  word_t         wr_data,
	input  logic [AW-1:0] rd_addr0,
	input  logic [AW-1:0] rd_addr1,
	output word_t         rd_data0,
	output word_t         rd_data1
);

	word_t mem_q [2**AW];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read data
	always_ff @(posedge clk) begin
		rd_data0 <= mem_q[rd_addr0];
		rd_data1 <= mem_q[rd_addr1];
	end

endmodule

// File: src/merge_sort_bottom_up.sv
// Bottom-up merge sorter top level: load, ping-pong merge passes, sorted readout.
// A value beyond MAX_ELEMENTS is dropped and flagged.
// Sorting n values takes ceil(log2(n)) passes; each merge step reads the source buffer
// (ST_MRD), then compares the run heads and writes one element (ST_MCMP).
// Readout reads each value (ST_ORD), then stages it in the output register (ST_OWAIT).
// Loading of the next set starts once the final result is staged.
// Reset clears the control state and counts; the buffers are not cleared and need no pass.
module merge_sort_bottom_up import mst_pkg::*; #(
	parameter int unsigned MAX_ELEMENTS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load_valid,
	output logic         load_stall,
	input  load_item_t   load_data,
	output logic         result_valid,
	input  logic         result_stall,
	output result_item_t result_data
);

	// AW indexes the buffers, CW holds a count up to MAX_ELEMENTS, SW holds run bounds
	// that reach up to twice the count during the merge bookkeeping.
	localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
	localparam int unsigned SW = CW + 1;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_MRD,
		ST_MCMP,
		ST_ORD,
		ST_OWAIT
	} state_t;

	state_t state_q;

	logic [CW-1:0] cnt_q;     // values stored for the current set
	logic          ovf_q;     // a value of this set was dropped
	logic [CW-1:0] n_q;       // set size frozen at the last transaction
	logic          src_q;     // 0: buffer A holds the current runs, 1: buffer B
	logic [SW-1:0] run_q;     // current run width
	logic [SW-1:0] lo_q;      // start of the current pair of runs
	logic [SW-1:0] md_q;      // end of the left run
	logic [SW-1:0] hi_q;      // end of the right run
	logic [SW-1:0] a_q;       // left run read pointer
	logic [SW-1:0] b_q;       // right run read pointer
	logic [SW-1:0] o_q;       // merge write pointer
	logic [CW-1:0] k_q;       // readout index
	logic          res_valid_q;
	result_item_t  res_data_q;

	// buffer ports
	logic          wa_en;
	logic [AW-1:0] wa_addr;
	word_t         wa_data;
	logic          wb_en;
	logic [AW-1:0] rd_addr0;
	logic [AW-1:0] rd_addr1;
	word_t         rda0, rda1, rdb0, rdb1;

	// merge datapath
	logic signed [DATA_W-1:0] head_a, head_b;
	logic                     a_ok, b_ok, take_a;
	word_t                    merged;
	logic [SW-1:0]            n_ext, run_dbl, lo_nx;
	logic [SW-1:0]            seg_md, seg_hi, pass_md, pass_hi;
	logic                     seg_end, pass_end, sort_end;

	// load side
	logic          load_take;
	logic          has_room;
	logic [CW-1:0] n_new;

	function automatic logic [SW-1:0] min_sw(input logic [SW-1:0] x, input logic [SW-1:0] y);
		min_sw = (x < y) ? x : y;
	endfunction

	assign load_stall = (state_q != ST_LOAD);
	assign load_take  = load_valid && !load_stall;
	assign has_room   = (cnt_q < CW'(MAX_ELEMENTS));
	assign n_new      = has_room ? (cnt_q + CW'(1)) : cnt_q;

	// Both buffers see the same read addresses; the source select picks the data.
	assign rd_addr0 = (state_q == ST_ORD) ? k_q[AW-1:0] : a_q[AW-1:0];
	assign rd_addr1 = b_q[AW-1:0];

	assign head_a = src_q ? rdb0 : rda0;
	assign head_b = src_q ? rdb1 : rda1;

	// Stable merge: on a tie the left run wins; an exhausted run never wins.
	assign a_ok   = (a_q < md_q);
	assign b_ok   = (b_q < hi_q);
	assign take_a = a_ok && (!b_ok || (head_a <= head_b));
	assign merged = take_a ? word_t'(head_a) : word_t'(head_b);

	// Next pair of runs in this pass, or first pair of the next pass.
	assign n_ext    = SW'(n_q);
	assign run_dbl  = {run_q[SW-2:0], 1'b0};
	assign lo_nx    = lo_q + run_dbl;
	assign seg_md   = min_sw(lo_nx + run_q, n_ext);
	assign seg_hi   = min_sw(lo_nx + run_dbl, n_ext);
	assign pass_md  = min_sw(run_dbl, n_ext);
	assign pass_hi  = min_sw({run_dbl[SW-2:0], 1'b0}, n_ext);
	assign seg_end  = ((o_q + SW'(1)) == hi_q);
	assign pass_end = (lo_nx >= n_ext);
	assign sort_end = (run_dbl >= n_ext);

	// Buffer A takes loads and the merge output while B is the source; B takes it while A is.
	always_comb begin
		wa_en   = 1'b0;
		wa_addr = o_q[AW-1:0];
		wa_data = merged;
		wb_en   = 1'b0;
		case (state_q)
			ST_LOAD: begin
				wa_en   = load_take && has_room;
				wa_addr = cnt_q[AW-1:0];
				wa_data = word_t'(load_data.element_value);
			end
			ST_MCMP: begin
				wa_en = src_q;
				wb_en = !src_q;
			end
			default: begin
			end
		endcase
	end

	mst_ram #(.AW(AW)) u_ram_a (
		.clk      (clk),
		.wr_en    (wa_en),
		.wr_addr  (wa_addr),
		.wr_data  (wa_data),
		.rd_addr0 (rd_addr0),
		.rd_addr1 (rd_addr1),
		.rd_data0 (rda0),
		.rd_data1 (rda1)
	);

	mst_ram #(.AW(AW)) u_ram_b (
		.clk      (clk),
		.wr_en    (wb_en),
		.wr_addr  (o_q[AW-1:0]),
		.wr_data  (merged),
		.rd_addr0 (rd_addr0),
		.rd_addr1 (rd_addr1),
		.rd_data0 (rdb0),
		.rd_data1 (rdb1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			n_q         <= '0;
			src_q       <= 1'b0;
			run_q       <= '0;
			lo_q        <= '0;
			md_q        <= '0;
			hi_q        <= '0;
			a_q         <= '0;
			b_q         <= '0;
			o_q         <= '0;
			k_q         <= '0;
			res_valid_q <= 1'b0;
			res_data_q  <= '0;
		end else begin
			// drop the staged result once the sink takes the transaction
			if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (load_take) begin
						cnt_q <= n_new;
						if (!has_room) begin
							ovf_q <= 1'b1;
						end
						if (load_data.set_last) begin
							n_q   <= n_new;
							src_q <= 1'b0;
							k_q   <= '0;
							run_q <= SW'(1);
							lo_q  <= '0;
							a_q   <= '0;
							o_q   <= '0;
							md_q  <= SW'(1);
							b_q   <= SW'(1);
							hi_q  <= SW'(2);
							// a single value needs no pass
							state_q <= (n_new > CW'(1)) ? ST_MRD : ST_ORD;
						end
					end
				end
				ST_MRD: begin
					state_q <= ST_MCMP;
				end
				ST_MCMP: begin
					o_q <= o_q + SW'(1);
					if (take_a) begin
						a_q <= a_q + SW'(1);
					end else begin
						b_q <= b_q + SW'(1);
					end
					state_q <= ST_MRD;
					if (seg_end) begin
						if (pass_end) begin
							// swap buffer roles and double the run width
							src_q <= !src_q;
							run_q <= run_dbl;
							lo_q  <= '0;
							a_q   <= '0;
							o_q   <= '0;
							md_q  <= pass_md;
							b_q   <= pass_md;
							hi_q  <= pass_hi;
							if (sort_end) begin
								k_q     <= '0;
								state_q <= ST_ORD;
							end
						end else begin
							lo_q <= lo_nx;
							a_q  <= lo_nx;
							o_q  <= lo_nx;
							md_q <= seg_md;
							b_q  <= seg_md;
							hi_q <= seg_hi;
						end
					end
				end
				ST_ORD: begin
					// issue the read only when the output register is free by next cycle
					if (!res_valid_q || !result_stall) begin
						state_q <= ST_OWAIT;
					end
				end
				ST_OWAIT: begin
					res_valid_q              <= 1'b1;
					res_data_q.sorted_value  <= head_a;
					res_data_q.result_last   <= (k_q == (n_q - CW'(1)));
					res_data_q.overflow_seen <= ovf_q;
					if (k_q == (n_q - CW'(1))) begin
						cnt_q   <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_LOAD;
					end else begin
						k_q     <= k_q + CW'(1);
						state_q <= ST_ORD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign result_data  = res_data_q;

`ifndef SYNTH
	// The fill count never passes the capacity.
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_ELEMENTS))
		else $error("fill count beyond capacity");

	// Every merge step has at least one run that still holds a value.
	a_merge_src: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MCMP) |-> (a_ok || b_ok))
		else $error("merge step with both runs exhausted");

	// The merge never writes beyond the loaded set.
	a_merge_dst: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MCMP) |-> (o_q < n_ext))
		else $error("merge write beyond set size");

	// A result is staged only into a free output register.
	a_stage_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OWAIT) |-> !res_valid_q)
		else $error("result staged over a pending transaction");
`endif

endmodule

// File: tb/sv/merge_sort_bottom_up_tb.sv
// Self-checking testbench for the bottom-up merge sorter: directed and random sets.
`timescale 1ns / 1ps

module merge_sort_bottom_up_tb;
	import mst_pkg::*;

	// Buffer capacity of the instance under test; the prediction uses the same figure.
	localparam int unsigned CAPACITY = 64;
	// Generous bound on the run, to catch a hung run.
	localparam int unsigned CYCLE_LIMIT = 400000;
	// Quiet time after the last result; covers a full sort of the largest set.
	localparam int unsigned DRAIN_CYCLES = 1000;

	localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         load_valid = 1'b0;
	logic         load_stall;
	load_item_t   load_data = '0;
	logic         result_valid;
	logic         result_stall = 1'b0;
	result_item_t result_data;

	// Idle and stall rates, in percent, for the current phase.
	int unsigned send_idle_pct = 0;
	int unsigned sink_stall_pct = 0;

	int unsigned cycle_count = 0;
	int unsigned mismatch_count = 0;

	// Predictor state: values of the set being loaded, in arrival order.
	logic signed [DATA_W-1:0] loaded_values[CAPACITY];
	int unsigned              loaded_total = 0;
	logic                     dropped_any = 1'b0;

	// Sorted results still owed by the block, oldest first.
	result_item_t sorted_results_due[$];

	merge_sort_bottom_up #(
		.MAX_ELEMENTS(CAPACITY)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.load_valid  (load_valid),
		.load_stall  (load_stall),
		.load_data   (load_data),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_data (result_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Stall the result channel at the rate of the current phase.
	always @(posedge clk) begin
		result_stall <= ($urandom_range(0, 99) < sink_stall_pct);
	end

	// Sort the loaded values in place: bottom-up passes of run width 1, 2, 4 ...
	// On ties the left run goes first, which keeps the sort stable.
	task automatic merge_sort_loaded(input int unsigned n);
		logic signed [DATA_W-1:0] merged[CAPACITY];
		int unsigned width, lo, mid, hi, a, b, o;
		for (width = 1; width < n; width = width * 2) begin
			for (lo = 0; lo < n; lo = lo + 2 * width) begin
				mid = (lo + width < n) ? lo + width : n;
				hi = (lo + 2 * width < n) ? lo + 2 * width : n;
				a = lo;
				b = mid;
				for (o = lo; o < hi; o++) begin
					if (a < mid && (b >= hi || loaded_values[a] <= loaded_values[b])) begin
						merged[o] = loaded_values[a];
						a++;
					end else begin
						merged[o] = loaded_values[b];
						b++;
					end
				end
				for (o = lo; o < hi; o++)
					loaded_values[o] = merged[o];
			end
		end
	endtask

	// Apply one accepted load transaction to the predictor. On the last value of a
	// set, sort what was kept and queue one result per kept value.
	task automatic predict_load(input load_item_t txn);
		result_item_t res;
		int unsigned k;
		// Keep the value while there is room, else drop it and flag the set.
		if (loaded_total < CAPACITY) begin
			loaded_values[loaded_total] = txn.element_value;
			loaded_total++;
		end else begin
			dropped_any = 1'b1;
		end
		if (txn.set_last) begin
			merge_sort_loaded(loaded_total);
			for (k = 0; k < loaded_total; k++) begin
				res.sorted_value = loaded_values[k];
				res.result_last = (k + 1 == loaded_total);
				res.overflow_seen = dropped_any;
				sorted_results_due.push_back(res);
			end
			// Start the next set empty and clean.
			loaded_total = 0;
			dropped_any = 1'b0;
		end
	endtask

	// Compare every accepted result with the oldest expectation, field by field.
	always @(posedge clk) begin
		result_item_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (sorted_results_due.size() == 0) begin
				$error("result with none expected: sorted_value %0d", result_data.sorted_value);
				mismatch_count++;
			end else begin
				want = sorted_results_due.pop_front();
				if (result_data.sorted_value !== want.sorted_value) begin
					$error("sorted_value: expected %0d, got %0d",
						want.sorted_value, result_data.sorted_value);
					mismatch_count++;
				end
				if (result_data.result_last !== want.result_last) begin
					$error("result_last: expected %0b, got %0b",
						want.result_last, result_data.result_last);
					mismatch_count++;
				end
				if (result_data.overflow_seen !== want.overflow_seen) begin
					$error("overflow_seen: expected %0b, got %0b",
						want.overflow_seen, result_data.overflow_seen);
					mismatch_count++;
				end
			end
		end
	end

	// Send one value; hold valid and payload until the block takes it.
	// Called at a rising edge; returns at the edge that accepted the transaction.
	task automatic send_element(input logic signed [DATA_W-1:0] value, input logic last);
		load_item_t txn;
		txn.element_value = value;
		txn.set_last = last;
		// Insert idle cycles at the phase's rate before offering the transaction.
		while ($urandom_range(0, 99) < send_idle_pct) begin
			load_valid <= 1'b0;
			@(posedge clk);
		end
		load_valid <= 1'b1;
		load_data <= txn;
		do
			@(posedge clk);
		while (load_stall);
		predict_load(txn);
	endtask

	// Pick a value: extremes, a narrow band around zero for ties, or any pattern.
	function automatic logic signed [DATA_W-1:0] rand_element();
		int unsigned pick;
		pick = $urandom_range(0, 7);
		case (pick)
			0: begin
				return WORD_MIN;
			end
			1: begin
				return WORD_MAX;
			end
			2, 3: begin
				return $signed($urandom_range(0, 6)) - 3;
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	task automatic send_random_set(input int unsigned len);
		int unsigned i;
		for (i = 0; i < len; i++)
			send_element(rand_element(), i + 1 == len);
	endtask

	// Sets of one value: both extremes, zero and minus one.
	task automatic test_single_values();
		send_element(WORD_MIN, 1'b1);
		send_element(WORD_MAX, 1'b1);
		send_element(32'sd0, 1'b1);
		send_element(-32'sd1, 1'b1);
	endtask

	// Pairs of the extremes in both orders; the sign bit decides the order.
	task automatic test_extreme_pairs();
		send_element(WORD_MAX, 1'b0);
		send_element(WORD_MIN, 1'b1);
		send_element(WORD_MIN, 1'b0);
		send_element(WORD_MAX, 1'b1);
	endtask

	// Repeated values spread over runs that get merged at different widths.
	task automatic test_duplicates();
		send_element(32'sd5, 1'b0);
		send_element(32'sd3, 1'b0);
		send_element(32'sd3, 1'b0);
		send_element(-32'sd7, 1'b0);
		send_element(32'sd5, 1'b0);
		send_element(32'sd0, 1'b1);
	endtask

	// Descending set of odd length with alternating bit patterns, so runs are uneven.
	task automatic test_reverse_order();
		send_element(WORD_MAX, 1'b0);
		send_element(32'sh5555_5555, 1'b0);
		send_element(32'sh0000_0001, 1'b0);
		send_element(-32'sd1, 1'b0);
		send_element(32'shaaaa_aaaa, 1'b0);
		send_element(32'sh8000_0001, 1'b0);
		send_element(WORD_MIN, 1'b1);
	endtask

	// Fill the buffer exactly, then overrun it by one and by three values: the surplus at the
	// end of the set is dropped and every result of such a set carries the overflow flag.
	task automatic test_capacity();
		send_random_set(CAPACITY);
		send_random_set(CAPACITY + 1);
		send_random_set(CAPACITY + 3);
	endtask

	// Random sets, mostly short, with the given idle and stall rates.
	task automatic test_random_sets(input int unsigned idle_pct, input int unsigned stall_pct,
			input int unsigned budget);
		int unsigned sent;
		int unsigned len;
		send_idle_pct = idle_pct;
		sink_stall_pct = stall_pct;
		sent = 0;
		while (sent < budget) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
			send_random_set(len);
			sent = sent + len;
		end
	endtask

	initial begin
		// Hold reset, then release it at a rising edge.
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		test_single_values();
		test_extreme_pairs();
		test_duplicates();
		test_reverse_order();

		// Random part: no idling, sender idle, receiver stalling, then both.
		test_random_sets(0, 0, 20);
		test_random_sets(78, 0, 20);
		test_random_sets(0, 78, 20);
		test_random_sets(13, 13, 20);
		test_capacity();

		// Drop valid and wait for the last results plus a quiet period.
		load_valid <= 1'b0;
		while (sorted_results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: files.f
src/mst_pkg.sv
src/mst_ram.sv
src/merge_sort_bottom_up.sv
tb/sv/merge_sort_bottom_up_tb.sv
